### design/hrpb_pkg.sv
package hrpb_pkg;

   localparam int WordCount = 24;
   localparam logic [31:0] ChkConstA = 32'd20000711;
   localparam logic [31:0] ChkConstB = 32'd126;
   localparam logic [31:0] ChkMult   = 32'd19680126;
   localparam logic [31:0] HashInitA = 32'h67452301;
   localparam logic [31:0] HashInitB = 32'hefcdab89;
   localparam logic [31:0] HashInitC = 32'h98badcfe;
   localparam logic [31:0] HashInitD = 32'h10325476;
   localparam logic [31:0] HashInitE = 32'hc3d2e1f0;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_MD5   = 2'd1,
      MODE_MD4   = 2'd2,
      MODE_SHA1  = 2'd3
   } hash_mode_type;

   typedef struct packed {
      logic       start;
      logic [1:0] mode;
   } hash_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] check;
   } hash_sts_type;

   function automatic logic [31:0] md5_k(input logic [5:0] i);
      logic [31:0] t [64];
      t = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
         32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
         32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
         32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
         32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
         32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return t[i];
   endfunction

   function automatic logic [4:0] md5_s(input logic [3:0] i);
      logic [4:0] t [16];
      t = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
            5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
      return t[i];
   endfunction

   function automatic logic [4:0] md4_s(input logic [3:0] i);
      logic [4:0] t [16];
      t = '{5'd3, 5'd7, 5'd11, 5'd19, 5'd3, 5'd5, 5'd9, 5'd13,
            5'd3, 5'd9, 5'd11, 5'd15, 5'd0, 5'd0, 5'd0, 5'd0};
      return t[i];
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] d;
      d = {x, x} << s;
      return d[63:32];
   endfunction

endpackage

### design/hrpb_if.sv
interface hrpb_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  packet_id;
   logic        use_hash;
   logic [31:0] seed_bytes;
   logic [31:0] server_ip;
   modport source (output valid, packet_id, use_hash, seed_bytes, server_ip, input ready);
   modport sink (input valid, packet_id, use_hash, seed_bytes, server_ip, output ready);
endinterface

interface hrpb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] packet_word;
   logic [4:0]  word_number;
   logic        last_word;
   modport source (output valid, packet_word, word_number, last_word, input ready);
   modport sink (input valid, packet_word, word_number, last_word, output ready);
endinterface

### design/heartbeat_request_packet_builder.sv
// heartbeat request packet builder: one request transaction yields a 96-byte packet sent
// as 24 rsp transactions of one 32-bit little-endian word each, word_number 0..23 and
// last_word on word 23. plain checksums take an xor step and then a multiply step before
// the first word is loaded; hashed requests with seed bits 1:0 zero use the fixed
// constants and go straight to sending; other hashed checksums run a single shared round
// unit one round per cycle through all md4, md5 or sha-1 rounds before the first word,
// then one word per cycle while rsp_ready holds. req_ready is low from acceptance until
// the last word is taken. csr_session_flag_byte is byte 19 of every packet; byte 17 is
// 0x62 on the first packet after reset and 0x63 afterwards.
module heartbeat_request_packet_builder (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   hrpb_req_if.sink   req,
   hrpb_rsp_if.source rsp
);
   import hrpb_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_XOR, S_MUL, S_HASH, S_SEND} state_type;

   state_type   state_ff;
   logic [7:0]  flag_ff;
   logic        first_sent_ff;
   logic [7:0]  id_ff;
   logic [31:0] seed_ff, ip_ff;
   logic        opt63_ff;
   logic [31:0] x_ff, w6_ff, w7_ff;
   logic [4:0]  idx_ff;
   logic        valid_ff;
   logic [31:0] word_ff;
   hash_cmd_type cmd_ff;
   hash_sts_type sts;
   logic [31:0] w0, w1, w4, cur;
   logic [63:0] prod;

   assign w0 = {8'h00, 8'h60, id_ff, 8'h07};
   assign w1 = 32'h00000003;
   assign w4 = {flag_ff, 8'h00, opt63_ff ? 8'h63 : 8'h62, 8'h00};
   assign prod = x_ff * ChkMult;

   hrpb_hash u_hash (.clock(clock), .reset(reset), .cmd(cmd_ff), .seed(seed_ff), .sts(sts));

   // word mux
   always_comb begin
      case (idx_ff)
         5'd0: cur = w0;
         5'd1: cur = w1;
         5'd3: cur = ip_ff;
         5'd4: cur = w4;
         5'd5: cur = seed_ff;
         5'd6: cur = w6_ff;
         5'd7: cur = w7_ff;
         default: cur = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         flag_ff       <= '0;
         first_sent_ff <= 1'b0;
         valid_ff      <= 1'b0;
         idx_ff        <= '0;
         cmd_ff        <= '0;
      end else begin
         // hash start pulse on acceptance of a hashed request that needs a digest
         cmd_ff.start <= (state_ff == S_IDLE) && req.valid && req.use_hash &&
                         (req.seed_bytes[1:0] != MODE_PLAIN);
         if (csr_write_enable) flag_ff <= csr_write_data;
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  id_ff         <= req.packet_id;
                  seed_ff       <= req.seed_bytes;
                  ip_ff         <= req.server_ip;
                  opt63_ff      <= first_sent_ff;
                  first_sent_ff <= 1'b1;
                  idx_ff        <= '0;
                  if (!req.use_hash) state_ff <= S_XOR;
                  else if (req.seed_bytes[1:0] == MODE_PLAIN) begin
                     w6_ff <= ChkConstA; w7_ff <= ChkConstB; state_ff <= S_SEND;
                  end else begin
                     cmd_ff.mode <= req.seed_bytes[1:0];
                     state_ff <= S_HASH;
                  end
               end
            end
            S_XOR: begin
               // xor of words 0..7 with the preset constants in 6 and 7
               x_ff <= w0 ^ w1 ^ ip_ff ^ w4 ^ seed_ff ^ ChkConstA ^ ChkConstB;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               w6_ff <= prod[31:0]; w7_ff <= '0; state_ff <= S_SEND;
            end
            S_HASH: begin
               if (sts.done) begin
                  w6_ff <= sts.check[31:0]; w7_ff <= sts.check[63:32];
                  state_ff <= S_SEND;
               end
            end
            S_SEND: begin
               // output register: load next word when empty or taken
               if (!valid_ff || rsp.ready) begin
                  if (valid_ff && rsp.last_word) begin
                     valid_ff <= 1'b0; state_ff <= S_IDLE; idx_ff <= '0;
                  end else begin
                     valid_ff <= 1'b1;
                     word_ff  <= cur;
                     rsp.word_number <= idx_ff;
                     rsp.last_word   <= (idx_ff == 5'(WordCount - 1));
                     idx_ff <= idx_ff + 5'd1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = valid_ff;
   assign rsp.packet_word = word_ff;

`ifndef SYNTHESIS
   a_no_valid_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !rsp.valid) else $error("rsp valid while idle");
   a_first: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> first_sent_ff) else $error("first flag not set");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last_word |=> state_ff == S_IDLE)
      else $error("packet end missed");
`endif
endmodule

### design/hrpb_hash.sv
module hrpb_hash (
   input  logic                  clock,
   input  logic                  reset,
   input  hrpb_pkg::hash_cmd_type cmd,
   input  logic [31:0]           seed,
   output hrpb_pkg::hash_sts_type sts
);
   import hrpb_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_type;

   state_type   state_ff;
   logic [6:0]  rnd_ff;
   logic [1:0]  mode_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] w_ff [16];
   logic [63:0] check_ff;
   logic        done_ff;

   logic [31:0] mw [16];
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] f, k, msg, t;
   logic [3:0]  gidx;
   logic [4:0]  sh;
   logic [1:0]  r4;
   logic [6:0]  last_rnd;
   logic [31:0] h0, h1, h2, h3, h4, sw;
   logic [7:0]  dg [20];
   logic [63:0] pick;

   // padded one-block message: seed + 0x80 + length 32 bits
   always_comb begin
      for (int i = 0; i < 16; i++) mw[i] = '0;
      if (mode_ff == MODE_SHA1) begin
         mw[0]  = {seed[7:0], seed[15:8], seed[23:16], seed[31:24]};
         mw[1]  = 32'h80000000;
         mw[15] = 32'd32;
      end else begin
         mw[0]  = seed;
         mw[1]  = 32'h00000080;
         mw[14] = 32'd32;
      end
   end

   // one round of the selected hash
   always_comb begin
      r4 = rnd_ff[5:4];
      f = '0; k = '0; gidx = rnd_ff[3:0]; sh = '0; msg = '0; t = '0;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      case (mode_ff)
         MODE_MD5: begin
            case (r4)
               2'd0: begin f = (b_ff & c_ff) | (~b_ff & d_ff); gidx = rnd_ff[3:0]; end
               2'd1: begin
                  f = (d_ff & b_ff) | (~d_ff & c_ff);
                  gidx = 4'(5 * rnd_ff[3:0] + 1);
               end
               2'd2: begin f = b_ff ^ c_ff ^ d_ff; gidx = 4'(3 * rnd_ff[3:0] + 5); end
               default: begin f = c_ff ^ (b_ff | ~d_ff); gidx = 4'(7 * rnd_ff[3:0]); end
            endcase
            sh = md5_s({r4, rnd_ff[1:0]});
            t = b_ff + rotl(a_ff + f + md5_k(rnd_ff[5:0]) + w_ff[gidx], sh);
            a_in = d_ff; d_in = c_ff; c_in = b_ff; b_in = t;
         end
         MODE_MD4: begin
            case (r4)
               2'd0: begin f = (b_ff & c_ff) | (~b_ff & d_ff); k = '0;
                  gidx = rnd_ff[3:0]; end
               2'd1: begin f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
                  k = 32'h5a827999; gidx = {rnd_ff[1:0], rnd_ff[3:2]}; end
               default: begin f = b_ff ^ c_ff ^ d_ff; k = 32'h6ed9eba1;
                  gidx = {rnd_ff[0], rnd_ff[1], rnd_ff[2], rnd_ff[3]}; end
            endcase
            sh = md4_s({r4, rnd_ff[1:0]});
            t = rotl(a_ff + f + w_ff[gidx] + k, sh);
            a_in = d_ff; d_in = c_ff; c_in = b_ff; b_in = t;
         end
         default: begin
            if (rnd_ff < 7'd20) begin
               f = (b_ff & c_ff) | (~b_ff & d_ff); k = 32'h5a827999;
            end else if (rnd_ff < 7'd40) begin
               f = b_ff ^ c_ff ^ d_ff; k = 32'h6ed9eba1;
            end else if (rnd_ff < 7'd60) begin
               f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = 32'h8f1bbcdc;
            end else begin
               f = b_ff ^ c_ff ^ d_ff; k = 32'hca62c1d6;
            end
            // w_ff works as a 16-entry sliding schedule window, w_ff[0] is w[i]
            msg = w_ff[0];
            t = rotl(a_ff, 5'd5) + f + e_ff + k + msg;
            e_in = d_ff; d_in = c_ff; c_in = rotl(b_ff, 5'd30); b_in = a_ff; a_in = t;
         end
      endcase
   end

   assign sw = rotl(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 5'd1);
   assign last_rnd = (mode_ff == MODE_MD5) ? 7'd63 : (mode_ff == MODE_MD4) ? 7'd47 : 7'd79;

   // final digest and byte pick
   always_comb begin
      h0 = a_ff + HashInitA; h1 = b_ff + HashInitB; h2 = c_ff + HashInitC;
      h3 = d_ff + HashInitD; h4 = e_ff + HashInitE;
      for (int i = 0; i < 20; i++) dg[i] = '0;
      if (mode_ff == MODE_SHA1) begin
         for (int i = 0; i < 4; i++) begin
            dg[i]      = h0[31 - 8 * i -: 8];
            dg[4 + i]  = h1[31 - 8 * i -: 8];
            dg[8 + i]  = h2[31 - 8 * i -: 8];
            dg[12 + i] = h3[31 - 8 * i -: 8];
            dg[16 + i] = h4[31 - 8 * i -: 8];
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            dg[i]      = h0[8 * i +: 8];
            dg[4 + i]  = h1[8 * i +: 8];
            dg[8 + i]  = h2[8 * i +: 8];
            dg[12 + i] = h3[8 * i +: 8];
         end
      end
      case (mode_ff)
         MODE_MD5: pick = {dg[14], dg[13], dg[6], dg[5], dg[9], dg[8], dg[3], dg[2]};
         MODE_MD4: pick = {dg[12], dg[11], dg[5], dg[4], dg[9], dg[8], dg[2], dg[1]};
         default:  pick = {dg[16], dg[15], dg[6], dg[5], dg[10], dg[9], dg[3], dg[2]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
         rnd_ff   <= '0;
         mode_ff  <= MODE_MD5;
      end else begin
         done_ff <= (state_ff == S_IDLE) && (rnd_ff != 7'd0);
         case (state_ff)
            S_IDLE: begin
               if (rnd_ff != 7'd0) begin
                  // rounds finished: latch the picked digest bytes
                  check_ff <= pick;
                  rnd_ff   <= '0;
               end else if (cmd.start) begin
                  mode_ff  <= cmd.mode;
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               // load message and chaining values after mode settles
               for (int i = 0; i < 16; i++) w_ff[i] <= mw[i];
               a_ff <= HashInitA; b_ff <= HashInitB; c_ff <= HashInitC;
               d_ff <= HashInitD; e_ff <= HashInitE;
               state_ff <= S_RUN;
            end
            S_RUN: begin
               a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
               if (mode_ff == MODE_SHA1) begin
                  for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
                  w_ff[15] <= sw;
               end
               rnd_ff <= rnd_ff + 7'd1;
               if (rnd_ff == last_rnd) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign sts.done  = done_ff;
   assign sts.check = check_ff;

`ifndef SYNTHESIS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> state_ff == S_IDLE) else $error("done outside idle");
   a_rnd_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> rnd_ff <= 7'd79) else $error("round overrun");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      sts.done |=> !sts.done) else $error("done not a pulse");
`endif
endmodule
